[sv/tkh_pkg.sv]
// Package for the top-K min-heap selector: beat payload types, the heap entry
// type and the fixed constants of the block.
// No dependencies; used by tkh_ram's parent, top_k_min_heap_selector_unit.
`default_nettype none

package tkh_pkg;

    // Fixed field widths.
    localparam int SCORE_W = 32;
    localparam int INDEX_W = 32;
    localparam int RANK_W  = 6;

    // Mode codes of an input beat.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DRAIN  = 1'b1;

    // Reset contents of the heap and of the empty-index register.
    localparam logic [SCORE_W-1:0] SCORE_EMPTY       = 32'h0000_0000;
    localparam logic [INDEX_W-1:0] EMPTY_INDEX_RESET = 32'hFFFF_FFFF;

    // Input beat: insert a pair or drain the heap.
    typedef struct packed {
        logic               mode;
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
    } t_in_item;

    // Output beat: one heap entry per beat during a drain.
    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [INDEX_W-1:0] result_index;
        logic [SCORE_W-1:0] result_score;
        logic               last;
    } t_out_item;

    // One heap entry as stored in the heap memory.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [INDEX_W-1:0] index;
    } t_entry;

endpackage

`default_nettype wire

[sv/tkh_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the heap entries of the top-K selector.
`default_nettype none

module tkh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/top_k_min_heap_selector_unit.sv]
// Top level of the top-K selector: a min-heap in a RAM walked by a small sequencer.
// Depends on tkh_pkg (types, constants) and tkh_ram (heap storage).
//
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one beat per
// item. An insert beat offers a (score, index) pair; it enters the heap only
// when its score is greater than the smallest kept score, then sifts down.
// A drain beat emits all TOP_COUNT entries on the output channel (o_out_valid,
// i_out_stall, o_out_data), smallest first, with ranks TOP_COUNT-1 down to 0
// and last set on rank 0, and then empties the heap.
// The block works on one item at a time and holds o_in_stall high meanwhile.
// Each sift level uses the single RAM read port to read the left child, then
// the right child, and then compares and writes.
// A one-deep output register holds a finished beat; while it is full and
// i_out_stall is high the drain waits before loading the next one.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets the
// index reported for unused entries; it takes effect at the next heap clear.
// Reset is synchronous and active low; it empties the heap at once through
// per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module top_k_min_heap_selector_unit #(
    parameter int TOP_COUNT = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire tkh_pkg::t_in_item     i_in_data,
    // Output channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output tkh_pkg::t_out_item         o_out_data,
    // Configuration channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [tkh_pkg::INDEX_W-1:0] i_cfg_data
);

    // Address width of the heap and width of counters that can hold TOP_COUNT.
    localparam int AW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int CW = $clog2(TOP_COUNT + 1);
    localparam int EW = $bits(tkh_pkg::t_entry);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_SIFT = 3'd4;
    localparam logic [2:0] S_RDR  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;

    // Registers and their next values.
    logic [2:0]                     r_state, n_state;
    tkh_pkg::t_in_item              r_item, n_item;
    tkh_pkg::t_entry                r_x, n_x;
    tkh_pkg::t_entry                r_l, n_l;
    logic [AW-1:0]                  r_pos, n_pos;
    logic [CW-1:0]                  r_live, n_live;
    logic [CW-1:0]                  r_rem, n_rem;
    logic                           r_has_r, n_has_r;
    logic                           r_out_vld, n_out_vld;
    tkh_pkg::t_out_item             r_out, n_out;
    logic [TOP_COUNT-1:0]           r_vld;
    logic                           r_rd_vld;
    logic [tkh_pkg::INDEX_W-1:0]    r_empty_index;
    logic [tkh_pkg::INDEX_W-1:0]    r_clr_index, n_clr_index;

    // RAM interface and sequencer helpers.
    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    tkh_pkg::t_entry                ram_wdata;
    logic [EW-1:0]                  ram_rdata;
    tkh_pkg::t_entry                q_raw, q_eff;
    logic                           in_acc, out_free, vld_clear, sift_done;
    logic [CW:0]                    lc_w, rc_w, live_w;
    logic                           pick_r;
    tkh_pkg::t_entry                child;
    logic [AW-1:0]                  child_addr;

    tkh_ram #(
        .WIDTH (EW),
        .DEPTH (TOP_COUNT)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // An entry never written since the last clear reads as the cleared value.
    assign q_raw = ram_rdata;
    always_comb begin
        if (r_rd_vld) begin
            q_eff = q_raw;
        end else begin
            q_eff.score = tkh_pkg::SCORE_EMPTY;
            q_eff.index = r_clr_index;
        end
    end

    // Handshakes.
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Child positions of the current sift position and the live bound.
    assign lc_w   = {CW'(r_pos), 1'b1};
    assign rc_w   = lc_w + (CW + 1)'(1);
    assign live_w = {1'b0, r_live};

    // Smaller child, left one on a tie.
    assign pick_r     = r_has_r && (q_eff.score < r_l.score);
    assign child      = pick_r ? q_eff : r_l;
    assign child_addr = pick_r ? rc_w[AW-1:0] : lc_w[AW-1:0];

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_x         = r_x;
        n_l         = r_l;
        n_pos       = r_pos;
        n_live      = r_live;
        n_rem       = r_rem;
        n_has_r     = r_has_r;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;
        n_clr_index = r_clr_index;
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_x;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        vld_clear   = 1'b0;
        sift_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item  = i_in_data;
                    n_rem   = CW'(TOP_COUNT - 1);
                    ram_re  = 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_RD0: begin
                ram_re  = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_item.mode == tkh_pkg::MODE_INSERT) begin
                    // Insert only when the new score beats the smallest kept one.
                    if (r_item.score <= q_eff.score) begin
                        n_state = S_IDLE;
                    end else begin
                        n_x.score = r_item.score;
                        n_x.index = r_item.index;
                        n_pos     = '0;
                        n_live    = CW'(TOP_COUNT);
                        n_state   = S_SIFT;
                    end
                end else if (out_free) begin
                    // Emit the root, then refill it from the last live entry.
                    n_out_vld          = 1'b1;
                    n_out.rank         = tkh_pkg::RANK_W'(r_rem);
                    n_out.result_index = q_eff.index;
                    n_out.result_score = q_eff.score;
                    n_out.last         = (r_rem == '0);
                    if (r_rem == '0) begin
                        vld_clear   = 1'b1;
                        n_clr_index = r_empty_index;
                        n_state     = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_rem[AW-1:0];
                        n_state   = S_LAST;
                    end
                end
            end
            S_LAST: begin
                n_x     = q_eff;
                n_pos   = '0;
                n_live  = r_rem;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                // Read the left child, or settle here when there is none.
                if (lc_w < live_w) begin
                    ram_re    = 1'b1;
                    ram_raddr = lc_w[AW-1:0];
                    n_state   = S_RDR;
                end else begin
                    ram_we    = 1'b1;
                    sift_done = 1'b1;
                end
            end
            S_RDR: begin
                n_l     = q_eff;
                n_has_r = (rc_w < live_w);
                if (rc_w < live_w) begin
                    ram_re    = 1'b1;
                    ram_raddr = rc_w[AW-1:0];
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                // Swap down only when the smaller child is strictly smaller.
                ram_we = 1'b1;
                if (child.score < r_x.score) begin
                    ram_wdata = child;
                    n_pos     = child_addr;
                    n_state   = S_SIFT;
                end else begin
                    sift_done = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a sift: an insert is finished, a drain goes on with the next root.
        if (sift_done) begin
            if (r_item.mode == tkh_pkg::MODE_DRAIN) begin
                n_rem   = r_rem - CW'(1);
                n_state = S_RD0;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_vld     <= 1'b0;
            r_vld         <= '0;
            r_rd_vld      <= 1'b0;
            r_empty_index <= tkh_pkg::EMPTY_INDEX_RESET;
            r_clr_index   <= tkh_pkg::EMPTY_INDEX_RESET;
        end else begin
            r_state     <= n_state;
            r_out_vld   <= n_out_vld;
            r_clr_index <= n_clr_index;
            if (i_cfg_valid && o_cfg_ready) begin
                r_empty_index <= i_cfg_data;
            end
            if (vld_clear) begin
                r_vld <= '0;
            end else if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_vld[ram_raddr];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_x     <= n_x;
        r_l     <= n_l;
        r_pos   <= n_pos;
        r_live  <= n_live;
        r_rem   <= n_rem;
        r_has_r <= n_has_r;
        r_out   <= n_out;
    end

    // The last beat of a drain always carries rank zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> (o_out_data.rank == '0))
        else $error("last beat with nonzero rank");

    // The heap is never read and written at the same address in one cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("heap read and write collide");

    // The heap is only written while an item is in work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SIFT || r_state == S_CMP))
        else $error("heap write outside a sift");

    // A drain loads a new beat only when the output register is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("output beat overwritten while stalled");

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for top_k_min_heap_selector_unit: directed and random insert/drain traffic,
// every drained beat checked against a behavioral min-heap kept alongside the block.
// Depends on tkh_pkg for the beat types and constants, and on the block's RTL.

module tb;

    localparam int HEAP_N          = 16;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 75;

    // Idling styles, one per phase of the run.
    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE,
        PH_PRESSURE
    } t_phase;

    // One row of the directed table; typed rows carry the score and index that
    // every beat of the drain must show.
    typedef struct packed {
        tkh_pkg::t_in_item           item;
        logic                        typed;
        logic [tkh_pkg::SCORE_W-1:0] typed_score;
        logic [tkh_pkg::INDEX_W-1:0] typed_index;
    } t_stim_row;

    localparam int DIR_N = 16;
    localparam t_stim_row DIRECTED [DIR_N] = '{
        // Drain straight after reset: zero scores, reset empty index.
        '{'{tkh_pkg::MODE_DRAIN,  32'h0000_0000, 32'h0000_0000}, 1'b1,
          tkh_pkg::SCORE_EMPTY, tkh_pkg::EMPTY_INDEX_RESET},
        // A zero score never enters a fresh heap.
        '{'{tkh_pkg::MODE_INSERT, 32'h0000_0000, 32'h1234_5678}, 1'b0, 32'h0, 32'h0},
        // The clear after the first drain used the written empty index of zero.
        '{'{tkh_pkg::MODE_DRAIN,  32'h0000_0000, 32'h0000_0000}, 1'b1,
          tkh_pkg::SCORE_EMPTY, 32'h0000_0000},
        '{'{tkh_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b0, 32'h0, 32'h0},
        // Sign bit set and a NaN pattern order as plain unsigned values.
        '{'{tkh_pkg::MODE_INSERT, 32'h8000_0000, 32'hAAAA_AAAA}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h7FC0_0000, 32'h5555_5555}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h3F80_0000, 32'h0000_0001}, 1'b0, 32'h0, 32'h0},
        // Equal scores exercise the left-child tie rule.
        '{'{tkh_pkg::MODE_INSERT, 32'h4000_0000, 32'h0000_0010}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h4000_0000, 32'h0000_0011}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h4000_0000, 32'h0000_0012}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h4000_0000, 32'h0000_0013}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h0000_0001, 32'h0000_0020}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_INSERT, 32'h0000_0000, 32'h0000_0021}, 1'b0, 32'h0, 32'h0},
        '{'{tkh_pkg::MODE_DRAIN,  32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0, 32'h0},
        // A drain of an emptied heap shows only unused entries.
        '{'{tkh_pkg::MODE_DRAIN,  32'h0000_0000, 32'h0000_0000}, 1'b1,
          tkh_pkg::SCORE_EMPTY, 32'h0000_0000}
    };

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    tkh_pkg::t_in_item           in_data   = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    tkh_pkg::t_out_item          out_data;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [tkh_pkg::INDEX_W-1:0] cfg_data  = '0;

    t_phase             cur_phase = PH_STEADY;
    int                 mismatch_count = 0;
    tkh_pkg::t_out_item expected_beats [$];

    // Behavioral copy of the heap and of the empty-index register.
    logic [tkh_pkg::SCORE_W-1:0] heap_score [HEAP_N];
    logic [tkh_pkg::INDEX_W-1:0] heap_index [HEAP_N];
    logic [tkh_pkg::INDEX_W-1:0] kept_empty_index;

    always #5 clk = ~clk;

    top_k_min_heap_selector_unit #(
        .TOP_COUNT  (HEAP_N)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Refill every entry with a zero score and the current empty index.
    function automatic void heap_clear();
        for (int k = 0; k < HEAP_N; k++) begin
            heap_score[k] = tkh_pkg::SCORE_EMPTY;
            heap_index[k] = kept_empty_index;
        end
    endfunction

    // Move the root down among the first live entries; a swap needs a strictly
    // smaller child, and the left child wins a tie.
    function automatic void heap_sift_root(input int live);
        int                          pos;
        int                          pick;
        int                          lc;
        int                          rc;
        logic [tkh_pkg::SCORE_W-1:0] tmp_score;
        logic [tkh_pkg::INDEX_W-1:0] tmp_index;
        pos = 0;
        while (1) begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            pick = pos;
            if (lc < live && heap_score[lc] < heap_score[pick]) pick = lc;
            if (rc < live && heap_score[rc] < heap_score[pick]) pick = rc;
            if (pick == pos) break;
            tmp_score        = heap_score[pos];
            tmp_index        = heap_index[pos];
            heap_score[pos]  = heap_score[pick];
            heap_index[pos]  = heap_index[pick];
            heap_score[pick] = tmp_score;
            heap_index[pick] = tmp_index;
            pos = pick;
        end
    endfunction

    // Fold one accepted beat into the heap copy and queue the drain beats it causes.
    // took is low for an insert that the heap turns away.
    task automatic apply_to_heap(input tkh_pkg::t_in_item item, input bit typed,
                                 input logic [tkh_pkg::SCORE_W-1:0] typed_score,
                                 input logic [tkh_pkg::INDEX_W-1:0] typed_index,
                                 output bit took);
        tkh_pkg::t_out_item beat;
        int                 remaining;
        int                 k;
        took = 1'b1;
        if (item.mode == tkh_pkg::MODE_INSERT) begin
            if (item.score <= heap_score[0]) begin
                took = 1'b0;
            end else begin
                heap_score[0] = item.score;
                heap_index[0] = item.index;
                heap_sift_root(HEAP_N);
            end
        end else begin
            for (k = 0; k < HEAP_N; k++) begin
                remaining         = HEAP_N - k - 1;
                beat.rank         = remaining[tkh_pkg::RANK_W-1:0];
                beat.result_index = typed ? typed_index : heap_index[0];
                beat.result_score = typed ? typed_score : heap_score[0];
                beat.last         = (remaining == 0);
                expected_beats.push_back(beat);
                heap_score[0] = heap_score[remaining];
                heap_index[0] = heap_index[remaining];
                heap_sift_root(remaining);
            end
            heap_clear();
        end
    endtask

    // Offer one beat after a phase-dependent gap and hold it until accepted.
    task automatic send_item(input tkh_pkg::t_in_item item, input bit typed,
                             input logic [tkh_pkg::SCORE_W-1:0] typed_score,
                             input logic [tkh_pkg::INDEX_W-1:0] typed_index,
                             output bit took);
        int gap;
        gap = 0;
        if (cur_phase == PH_SENDER_IDLE) begin
            while ($urandom_range(0, 99) < 88) gap++;
        end else if (cur_phase == PH_BOTH_IDLE) begin
            while ($urandom_range(0, 99) < 36) gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        apply_to_heap(item, typed, typed_score, typed_index, took);
    endtask

    // Let every expected beat arrive, then give a trailing insert time to finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_empty_index(input logic [tkh_pkg::INDEX_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        kept_empty_index = value;
    endtask

    // Mostly inserts; scores mix full-range values, tiny values that collide,
    // float-like positives and the corner patterns.
    function automatic tkh_pkg::t_in_item random_item(input bit force_drain);
        tkh_pkg::t_in_item item;
        item.mode  = (force_drain || $urandom_range(0, 11) == 0) ?
                     tkh_pkg::MODE_DRAIN : tkh_pkg::MODE_INSERT;
        item.index = $urandom;
        case ($urandom_range(0, 3))
            0: item.score = $urandom;
            1: item.score = $urandom_range(0, 15);
            2: item.score = {1'b0, 8'($urandom_range(100, 140)), 23'($urandom)};
            default: begin
                case ($urandom_range(0, 3))
                    0: item.score = 32'h0000_0000;
                    1: item.score = 32'hFFFF_FFFF;
                    2: item.score = 32'h8000_0000;
                    default: item.score = 32'h7FFF_FFFF;
                endcase
            end
        endcase
        return item;
    endfunction

    // Receiver: random stalls per phase, plus one long hold-off at the start of
    // the pressure phase so the output fills and the input backs up.
    int hold_left    = 0;
    bit hold_started = 1'b0;
    always @(posedge clk) begin
        if (cur_phase == PH_PRESSURE && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            hold_left <= 0;
            case (cur_phase)
                PH_RECEIVER_STALL: out_stall <= ($urandom_range(0, 99) < 88);
                PH_BOTH_IDLE:      out_stall <= ($urandom_range(0, 99) < 36);
                default:           out_stall <= 1'b0;
            endcase
        end
    end

    // Compare every accepted output beat with the oldest expectation.
    always @(posedge clk) begin : check_out
        tkh_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat rank %0d", out_data.rank));
            end else begin
                want = expected_beats.pop_front();
                if (out_data.rank != want.rank)
                    report_mismatch($sformatf("rank %0d, want %0d",
                                              out_data.rank, want.rank));
                if (out_data.result_index != want.result_index)
                    report_mismatch($sformatf("rank %0d index %h, want %h", want.rank,
                                              out_data.result_index, want.result_index));
                if (out_data.result_score != want.result_score)
                    report_mismatch($sformatf("rank %0d score %h, want %h", want.rank,
                                              out_data.result_score, want.result_score));
                if (out_data.last != want.last)
                    report_mismatch($sformatf("rank %0d last %b, want %b", want.rank,
                                              out_data.last, want.last));
            end
        end
    end

    // Main sequence: reset, directed table, then one random run per idling phase.
    initial begin : stimulus
        tkh_pkg::t_in_item           item;
        bit                          took;
        int                          entered;
        logic [tkh_pkg::INDEX_W-1:0] cfg_value;
        kept_empty_index = tkh_pkg::EMPTY_INDEX_RESET;
        heap_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The new empty index shows only after the first drain clears the heap.
        write_empty_index(32'h0000_0000);
        for (int r = 0; r < DIR_N; r++) begin
            send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].typed_score,
                      DIRECTED[r].typed_index, took);
        end

        for (int p = PH_STEADY; p <= PH_PRESSURE; p++) begin
            wait_idle();
            case (p)
                PH_STEADY:         cfg_value = 32'hFFFF_FFFF;
                PH_RECEIVER_STALL: cfg_value = 32'h0000_0000;
                default:           cfg_value = $urandom;
            endcase
            write_empty_index(cfg_value);
            cur_phase = t_phase'(p);
            entered   = 0;
            while (entered < ITEMS_PER_PHASE) begin
                item = random_item(p == PH_PRESSURE && entered == 0);
                send_item(item, 1'b0, '0, '0, took);
                if (took) entered++;
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
